@@ hdl/wra_pkg.sv @@
package wra_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int PERIOD_W       = 9;
    localparam int PERIOD_LIMIT   = (1 << PERIOD_W) - 1;
    localparam int MAX_PERIOD_DEF = 256;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20);

    typedef struct packed {
        logic accept;
        logic start_div;
        logic finish;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ hdl/wra_ifs.sv @@
interface wra_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [wra_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface wra_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [wra_pkg::SAMPLE_W-1:0] average;
    logic                                valid_res;

    modport source (output valid, output average, output valid_res, input ready);
    modport sink (input valid, input average, input valid_res, output ready);
endinterface

interface wra_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [wra_pkg::PERIOD_W-1:0] period;

    modport source (output valid, output period, input ready);
    modport sink (input valid, input period, output ready);
endinterface

@@ hdl/wra_div.sv @@
module wra_div #(
    parameter int NUM_W = 41,
    parameter int DEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_diff;
    logic              fits;

    // restoring division, one quotient bit per cycle
    assign trial      = {rem_reg, quo_reg[NUM_W-1]};
    assign fits       = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/wra_dp.sv @@
module wra_dp #(
    parameter int MAX_PERIOD = wra_pkg::MAX_PERIOD_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wra_pkg::ctrl_cmd_t                  cmd,
    output wra_pkg::dp_status_t                 status,
    input  logic signed [wra_pkg::SAMPLE_W-1:0] sample,
    input  logic                                cfg_valid,
    input  logic [wra_pkg::PERIOD_W-1:0]        cfg_period,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [wra_pkg::SAMPLE_W-1:0] out_average,
    output logic                                out_valid_res
);

    localparam int SW      = wra_pkg::SAMPLE_W;
    localparam int PW      = wra_pkg::PERIOD_W;
    localparam int EFF_MAX = (MAX_PERIOD < wra_pkg::PERIOD_LIMIT) ?
                             MAX_PERIOD : wra_pkg::PERIOD_LIMIT;
    localparam int CNT_W   = $clog2(EFF_MAX + 1);
    localparam int SUM_W   = SW + CNT_W;
    localparam logic [PW-1:0] MAX_P = PW'(EFF_MAX);

    logic [PW-1:0]           period_reg, period_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SW-1:0]    avg_reg, avg_next;
    logic                    seeded_reg, seeded_next;
    logic signed [SW-1:0]    sample_reg;
    logic                    neg_reg;
    logic                    out_valid_reg, out_valid_next;
    logic signed [SW-1:0]    out_avg_reg;
    logic                    out_vres_reg;

    logic [PW-1:0]           clamp_p;
    logic [CNT_W-1:0]        eff_p;
    logic signed [SW:0]      diff;
    logic signed [SUM_W-1:0] num;
    logic [SUM_W-1:0]        mag;
    logic [SUM_W-1:0]        dividend;
    logic [SUM_W-1:0]        quotient;
    logic [SUM_W-1:0]        quo_signed;
    logic signed [SW-1:0]    q_step;
    logic                    div_done;

    // zero period acts as one, large periods saturate
    always_comb
    begin
        if (period_reg == '0)
            clamp_p = PW'(1);
        else if (period_reg > MAX_P)
            clamp_p = MAX_P;
        else
            clamp_p = period_reg;
    end
    assign eff_p = clamp_p[CNT_W-1:0];

    // seed mean divides the sum, smoothing divides the difference
    assign diff     = (SW+1)'(sample_reg) - (SW+1)'(avg_reg);
    assign num      = seeded_reg ? SUM_W'(diff) : sum_reg;
    assign mag      = num[SUM_W-1] ? (~num + SUM_W'(1)) : num;
    assign dividend = mag + {{(SUM_W-CNT_W){1'b0}}, eff_p >> 1};

    wra_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend (dividend),
        .divisor  (eff_p),
        .done     (div_done),
        .quotient (quotient)
    );

    assign quo_signed = neg_reg ? (~quotient + SUM_W'(1)) : quotient;
    assign q_step     = quo_signed[SW-1:0];

    always_comb
    begin
        period_next    = period_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        avg_next       = avg_reg;
        seeded_next    = seeded_reg;
        out_valid_next = out_valid_reg;

        if (cfg_valid)
        begin
            period_next = cfg_period;
            sum_next    = '0;
            count_next  = '0;
            avg_next    = '0;
            seeded_next = 1'b0;
        end
        else
        begin
            if (cmd.accept && !seeded_reg)
            begin
                sum_next   = sum_reg + SUM_W'(sample);
                count_next = count_reg + CNT_W'(1);
            end
            if (cmd.finish)
            begin
                seeded_next = 1'b1;
                avg_next    = seeded_reg ? (avg_reg + q_step) : q_step;
            end
        end

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= wra_pkg::PERIOD_RESET;
            sum_reg       <= '0;
            count_reg     <= '0;
            avg_reg       <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            period_reg    <= period_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            avg_reg       <= avg_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            sample_reg <= sample;
        if (cmd.start_div)
            neg_reg <= num[SUM_W-1];
        if (cmd.load_out)
        begin
            out_avg_reg  <= seeded_reg ? avg_reg : '0;
            out_vres_reg <= seeded_reg;
        end
    end

    assign status.need_div = seeded_reg || (count_reg >= eff_p);
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_average   = out_avg_reg;
    assign out_valid_res = out_vres_reg;

endmodule

@@ hdl/wra_ctrl.sv @@
module wra_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wra_pkg::dp_status_t status,
    output wra_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept    = 1'b1;
                    in_ready_next = 1'b0;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.need_div)
                begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_OUT;
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait for the output register to free up
                if (status.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    in_ready_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                in_ready_next = 1'b1;
                state_next    = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

@@ hdl/wilder_running_average_top.sv @@
// Wilder running average (RMA, alpha = 1/period) on signed Q16.16 samples. The first
// period samples are summed and the seed mean is given at the period-th one; after that each
// sample moves the average by (sample - average)/period, all divisions rounded to nearest
// with ties away from zero. Results before the seed carry valid_res = 0 and average = 0.
// One result per sample. Writing period clears the seed sum, count and average and restarts
// seeding; period 0 acts as 1 and values above MAX_PERIOD saturate. A sample that only adds
// to the seed sum skips the divider; a sample that divides uses the bit-serial divider, which
// is W = 32 + clog2(min(MAX_PERIOD, 511) + 1) bits wide and produces one quotient bit per
// cycle. One sample is in work at a time; a finished result waits in the output register
// while the next sample is taken.
module wilder_running_average_top #(
    parameter int MAX_PERIOD = wra_pkg::MAX_PERIOD_DEF
) (
    input logic       clk,
    input logic       rst_n,
    wra_in_if.sink    samples,
    wra_out_if.source results,
    wra_cfg_if.sink   cfg
);

    wra_pkg::ctrl_cmd_t  cmd;
    wra_pkg::dp_status_t status;
    logic                in_ready;

    wra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    wra_dp #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample        (samples.sample),
        .cfg_valid     (cfg.valid),
        .cfg_period    (cfg.period),
        .out_valid     (results.valid),
        .out_ready     (results.ready),
        .out_average   (results.average),
        .out_valid_res (results.valid_res)
    );

    assign samples.ready = in_ready;
    assign cfg.ready     = 1'b1;

endmodule

@@ hdl/wra_checker.sv @@
module wra_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [wra_pkg::SAMPLE_W-1:0] average,
    input logic                                valid_res
);

    // one sample in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a sample is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("input ready dropped without a transfer");

    // not-yet-seeded results carry a zero average
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (average == '0))
        else $error("unseeded result with nonzero average");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(average) && $stable(valid_res)))
        else $error("stalled result changed");

endmodule

bind wilder_running_average_top wra_checker u_wra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .average   (results.average),
    .valid_res (results.valid_res)
);

@@ tb/tb.sv @@
module tb;
    import wra_pkg::*;

    localparam int MAX_PERIOD  = MAX_PERIOD_DEF;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_GOAL = 1100;
    localparam int TAIL_COUNT  = 150;
    localparam int DRAIN_WAIT  = 60;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic                       valid_res;
    } rma_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wra_in_if  sample_ch ();
    wra_out_if result_ch ();
    wra_cfg_if cfg_ch ();

    wilder_running_average_top #(
        .MAX_PERIOD(MAX_PERIOD)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(sample_ch.sink),
        .results(result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    always #4 clk = ~clk;

    // smoothing state mirrored on the testbench side
    logic [PERIOD_W-1:0]        period_reg;
    longint                     seed_sum;
    int unsigned                seen_count;
    logic signed [SAMPLE_W-1:0] avg_now;
    bit                         seeded;

    rma_result_t                expected_avgs[$];
    int                         errors;
    int                         samples_sent;
    int                         averages_checked;
    int                         smoothed_seen;
    int                         period_writes;
    int                         stall_left;
    int                         idle_cycles;
    bit                         idle_on;
    logic signed [SAMPLE_W-1:0] last_price;

    function automatic int unsigned effective_period();
        int unsigned p;
        p = period_reg;
        if (p == 0)
            p = 1;
        if (p > MAX_PERIOD)
            p = MAX_PERIOD;
        return p;
    endfunction

    // ties go away from zero
    function automatic longint div_nearest(longint n, int unsigned d);
        longint unsigned mag;
        longint unsigned q;
        mag = (n < 0) ? 64'(-n) : 64'(n);
        q = (mag + 64'(d / 2)) / 64'(d);
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void clear_smoothing();
        seed_sum   = 0;
        seen_count = 0;
        avg_now    = '0;
        seeded     = 1'b0;
    endfunction

    function automatic rma_result_t rma_predict(logic signed [SAMPLE_W-1:0] x);
        int unsigned p;
        rma_result_t r;
        p = effective_period();
        if (!seeded) begin
            seed_sum += longint'(x);
            seen_count++;
            if (seen_count >= p) begin
                avg_now = SAMPLE_W'(div_nearest(seed_sum, p));
                seeded  = 1'b1;
            end
        end
        else begin
            avg_now = SAMPLE_W'(longint'(avg_now)
                                + div_nearest(longint'(x) - longint'(avg_now), p));
        end
        r.valid_res = seeded;
        r.average   = seeded ? avg_now : '0;
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7fff_ffff;
                    1:       return 32'sh8000_0000;
                    2:       return '0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3:
                return $urandom;
            default: begin
                // price-like drift around the previous value
                last_price = last_price + SAMPLE_W'($urandom_range(0, 2097152))
                             - 32'sd1048576;
                return last_price;
            end
        endcase
    endfunction

    // output side backpressure in bursts
    initial begin
        result_ch.ready = 1'b0;
        stall_left      = 0;
        forever begin
            @(posedge clk);
            if (!rst_n)
                result_ch.ready <= 1'b0;
            else if (stall_left != 0)
                stall_left <= stall_left - 1;
            else if (idle_on && result_ch.ready && $urandom_range(0, 11) == 0) begin
                result_ch.ready <= 1'b0;
                stall_left      <= $urandom_range(0, 12);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        rma_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_avgs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, average %0d valid_res %0b",
                         $time, result_ch.average, result_ch.valid_res);
            end
            else begin
                want = expected_avgs.pop_front();
                averages_checked++;
                if (want.valid_res)
                    smoothed_seen++;
                if (result_ch.average !== want.average) begin
                    errors++;
                    $display("%0t: average expected %0d actual %0d",
                             $time, want.average, result_ch.average);
                end
                if (result_ch.valid_res !== want.valid_res) begin
                    errors++;
                    $display("%0t: valid_res expected %0b actual %0b",
                             $time, want.valid_res, result_ch.valid_res);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= x;
        do @(posedge clk); while (sample_ch.ready !== 1'b1);
        expected_avgs.push_back(rma_predict(x));
        samples_sent++;
    endtask

    task automatic wait_drained();
        if (sample_ch.valid)
            sample_ch.valid <= 1'b0;
        while (expected_avgs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        wait_drained();
        cfg_ch.valid  <= 1'b1;
        cfg_ch.period <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        period_reg = value;
        clear_smoothing();
        period_writes++;
    endtask

    // reset value of period, nothing seeded yet
    task automatic test_default_period();
        send_sample(32'sh7fff_ffff);
        send_sample(32'sh8000_0000);
        send_sample('0);
    endtask

    // period 0 acts as 1, average follows the sample across full-scale swings
    task automatic test_period_zero();
        write_period('0);
        send_sample(32'sh7fff_ffff);
        send_sample(32'sh8000_0000);
        send_sample(32'sh7fff_ffff);
        send_sample(-32'sd1);
    endtask

    // half-way quotients, positive and negative
    task automatic test_rounding_ties();
        write_period(PERIOD_W'(2));
        send_sample(32'sd1);
        send_sample(32'sd2);
        send_sample(-32'sd3);
        send_sample('0);
        send_sample(-32'sd1);
    endtask

    // a write in the middle of seeding restarts it, oversize periods saturate
    task automatic test_reseed_on_write();
        write_period(PERIOD_W'(3));
        send_sample(32'sh0001_0000);
        send_sample(32'sh0002_8000);
        write_period(PERIOD_W'(257));
        send_sample(32'sh8000_0000);
        send_sample(32'sh8000_0000);
        write_period(PERIOD_W'(511));
        send_sample(32'sh7fff_ffff);
    endtask

    task automatic test_random_phases(input int goal);
        int unsigned p;
        int          len;
        int          phase;
        logic [PERIOD_W-1:0] forced[4];
        forced = '{PERIOD_W'(256), PERIOD_W'(1), PERIOD_W'(511), PERIOD_RESET};
        phase  = 0;
        while (samples_sent < goal) begin
            if (phase < 4)
                p = forced[phase];
            else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
                        p = $urandom_range(1, 8);
                    12, 13, 14, 15:
                        p = $urandom_range(9, 40);
                    16:
                        p = 0;
                    17:
                        p = ($urandom_range(0, 1) == 0) ? 256 : PERIOD_LIMIT;
                    default:
                        p = $urandom_range(0, PERIOD_LIMIT);
                endcase
            end
            phase++;
            write_period(PERIOD_W'(p));
            idle_on = ($urandom_range(0, 3) != 0);
            p = effective_period();
            len = (p > 16) ? int'(p) + $urandom_range(4, 24) : $urandom_range(8, 48);
            repeat (len) begin
                // now and then the sender holds off until every pending average is back
                if ($urandom_range(0, 59) == 0)
                    wait_drained();
                send_sample(pick_sample());
            end
        end
    endtask

    task automatic test_steady_tail();
        write_period(PERIOD_W'($urandom_range(1, 12)));
        idle_on = 1'b0;
        repeat (TAIL_COUNT)
            send_sample(pick_sample());
    endtask

    initial begin
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.period    = '0;
        errors           = 0;
        samples_sent     = 0;
        averages_checked = 0;
        smoothed_seen    = 0;
        period_writes    = 0;
        idle_cycles      = 0;
        idle_on          = 1'b1;
        last_price       = 32'sh0064_0000;
        period_reg       = PERIOD_RESET;
        clear_smoothing();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_default_period();
        test_period_zero();
        test_rounding_ties();
        test_reseed_on_write();
        test_random_phases(RANDOM_GOAL);
        test_steady_tail();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("%0d samples sent under %0d period writes, %0d averages compared",
                 samples_sent, period_writes, averages_checked);
        $display("%0d seeded averages; periods 0, 1, 2, 20, 256, 257, 511 and random",
                 smoothed_seen);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
